### hdl/wsfd_pkg.sv
package wsfd_pkg;

	// Result kinds.
	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	// Header parsing phases.
	localparam logic [2:0] PH_BYTE0   = 3'd0;
	localparam logic [2:0] PH_BYTE1   = 3'd1;
	localparam logic [2:0] PH_EXTLEN  = 3'd2;
	localparam logic [2:0] PH_KEY     = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;
	localparam logic [2:0] PH_DONE    = 3'd5;

	// Seven-bit length codes that select an extended length.
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	// Result queue depth.
	localparam int unsigned RES_DEPTH = 4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       buffer_end;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        fin;
		logic [3:0]  opcode;
		logic        masked;
		logic [31:0] mask_key;
		logic [63:0] payload_length;
		logic [7:0]  payload_byte;
		logic        last_in_frame;
	} out_beat_t;

endpackage

### hdl/websocket_frame_deframer.sv
// A result beat is written into the result queue when its input beat is accepted.
// Throughput: one input beat per cycle; a beat that causes two results (a result
// plus an early-end error) pushes both of them into a 4-entry queue.
// Input is stalled only while fewer than two queue entries are free.
// Reset (arst_n low, asynchronous) returns the parser to the first header byte
// and empties the result queue.
module websocket_frame_deframer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  wsfd_pkg::in_beat_t  byte_beat,
	output logic                result_valid,
	input  logic                result_stall,
	output wsfd_pkg::out_beat_t result_beat
);

	localparam int unsigned PTR_W = $clog2(wsfd_pkg::RES_DEPTH);
	localparam int unsigned CNT_W = $clog2(wsfd_pkg::RES_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_ROOM = CNT_W'(wsfd_pkg::RES_DEPTH - 2);

	// Parser state.
	logic [2:0]  phase_q;
	logic [3:0]  hdr_cnt_q;
	logic [63:0] len_q;
	logic [31:0] key_q;
	logic [63:0] remain_q;
	logic [1:0]  key_idx_q;
	logic        fin_q;
	logic [3:0]  opcode_q;
	logic        masked_q;

	logic [2:0]  phase_d;
	logic [3:0]  hdr_cnt_d;
	logic [63:0] len_d;
	logic [31:0] key_d;
	logic [63:0] remain_d;
	logic [1:0]  key_idx_d;
	logic        fin_d;
	logic [3:0]  opcode_d;
	logic        masked_d;

	// Results caused by the current beat.
	logic                res_hit;
	logic [1:0]          res_kind;
	logic [7:0]          res_byte;
	logic                res_last;
	logic                err_hit;
	wsfd_pkg::out_beat_t res_main;
	wsfd_pkg::out_beat_t res_err;

	// Result queue.
	wsfd_pkg::out_beat_t     queue_q [wsfd_pkg::RES_DEPTH];
	logic [PTR_W-1:0]        wr_ptr_q;
	logic [PTR_W-1:0]        rd_ptr_q;
	logic [CNT_W-1:0]        count_q;
	logic                    accept;
	logic                    pop;
	logic [1:0]              n_push;

	logic [7:0] b;
	logic [6:0] len7;
	logic [1:0] key_pos;
	logic [7:0] key_byte;

	assign accept = byte_valid && !byte_stall;
	assign pop    = result_valid && !result_stall;
	assign b      = byte_beat.data_byte;
	assign len7   = b[6:0];

	// Next parser state and the results of one input byte.
	always_comb begin
		phase_d   = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		len_d     = len_q;
		key_d     = key_q;
		remain_d  = remain_q;
		key_idx_d = key_idx_q;
		fin_d     = fin_q;
		opcode_d  = opcode_q;
		masked_d  = masked_q;
		res_hit   = 1'b0;
		res_kind  = wsfd_pkg::KIND_HEADER;
		res_byte  = 8'd0;
		res_last  = 1'b0;
		key_pos   = 2'd0;
		key_byte  = 8'd0;

		case (phase_q)
			wsfd_pkg::PH_BYTE0: begin
				fin_d     = b[7];
				opcode_d  = b[3:0];
				masked_d  = 1'b0;
				key_d     = 32'd0;
				len_d     = 64'd0;
				remain_d  = 64'd0;
				key_idx_d = 2'd0;
				hdr_cnt_d = 4'd0;
				phase_d   = wsfd_pkg::PH_BYTE1;
			end
			wsfd_pkg::PH_BYTE1: begin
				masked_d = b[7];
				len_d    = 64'd0;
				if (len7 == wsfd_pkg::LEN_EXT16) begin
					hdr_cnt_d = 4'd2;
					phase_d   = wsfd_pkg::PH_EXTLEN;
				end else if (len7 == wsfd_pkg::LEN_EXT64) begin
					hdr_cnt_d = 4'd8;
					phase_d   = wsfd_pkg::PH_EXTLEN;
				end else begin
					len_d = {57'd0, len7};
					if (b[7]) begin
						hdr_cnt_d = 4'd4;
						phase_d   = wsfd_pkg::PH_KEY;
					end else begin
						res_hit   = 1'b1;
						res_last  = (len7 == 7'd0);
						remain_d  = {57'd0, len7};
						key_idx_d = 2'd0;
						phase_d   = (len7 == 7'd0) ? wsfd_pkg::PH_DONE : wsfd_pkg::PH_PAYLOAD;
					end
				end
			end
			wsfd_pkg::PH_EXTLEN: begin
				len_d     = {len_q[55:0], b};
				hdr_cnt_d = hdr_cnt_q - 4'd1;
				if (hdr_cnt_q == 4'd1) begin
					if (masked_q) begin
						hdr_cnt_d = 4'd4;
						phase_d   = wsfd_pkg::PH_KEY;
					end else begin
						res_hit   = 1'b1;
						res_last  = (len_d == 64'd0);
						remain_d  = len_d;
						key_idx_d = 2'd0;
						phase_d   = (len_d == 64'd0) ? wsfd_pkg::PH_DONE
							: wsfd_pkg::PH_PAYLOAD;
					end
				end
			end
			wsfd_pkg::PH_KEY: begin
				// The count runs 4..1, placing wire bytes from the low end up.
				key_pos   = 2'd0 - hdr_cnt_q[1:0];
				case (key_pos)
					2'd0:    key_d = key_q | {24'd0, b};
					2'd1:    key_d = key_q | {16'd0, b, 8'd0};
					2'd2:    key_d = key_q | {8'd0, b, 16'd0};
					default: key_d = key_q | {b, 24'd0};
				endcase
				hdr_cnt_d = hdr_cnt_q - 4'd1;
				if (hdr_cnt_q == 4'd1) begin
					res_hit   = 1'b1;
					res_last  = (len_q == 64'd0);
					remain_d  = len_q;
					key_idx_d = 2'd0;
					phase_d   = (len_q == 64'd0) ? wsfd_pkg::PH_DONE : wsfd_pkg::PH_PAYLOAD;
				end
			end
			wsfd_pkg::PH_PAYLOAD: begin
				case (key_idx_q)
					2'd0:    key_byte = key_q[7:0];
					2'd1:    key_byte = key_q[15:8];
					2'd2:    key_byte = key_q[23:16];
					default: key_byte = key_q[31:24];
				endcase
				res_hit   = 1'b1;
				res_kind  = wsfd_pkg::KIND_PAYLOAD;
				res_byte  = masked_q ? (b ^ key_byte) : b;
				res_last  = (remain_q == 64'd1);
				key_idx_d = key_idx_q + 2'd1;
				remain_d  = remain_q - 64'd1;
				if (remain_q == 64'd1) begin
					phase_d = wsfd_pkg::PH_DONE;
				end
			end
			default: begin
				// Frame complete: bytes are ignored until the buffer ends.
			end
		endcase

		// End of buffer: report an unfinished frame, then restart.
		err_hit = byte_beat.buffer_end && (phase_d < wsfd_pkg::PH_DONE);
		if (byte_beat.buffer_end) begin
			phase_d   = wsfd_pkg::PH_BYTE0;
			hdr_cnt_d = 4'd0;
		end
	end

	// Result beats built from the updated header fields.
	always_comb begin
		res_main.kind           = res_kind;
		res_main.fin            = fin_d;
		res_main.opcode         = opcode_d;
		res_main.masked         = masked_d;
		res_main.mask_key       = key_d;
		res_main.payload_length = len_d;
		res_main.payload_byte   = res_byte;
		res_main.last_in_frame  = res_last;

		res_err      = '0;
		res_err.kind = wsfd_pkg::KIND_ERROR;
	end

	assign n_push = accept ? ({1'b0, res_hit} + {1'b0, err_hit}) : 2'd0;

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= wsfd_pkg::PH_BYTE0;
			hdr_cnt_q <= 4'd0;
			len_q     <= 64'd0;
			key_q     <= 32'd0;
			remain_q  <= 64'd0;
			key_idx_q <= 2'd0;
			fin_q     <= 1'b0;
			opcode_q  <= 4'd0;
			masked_q  <= 1'b0;
		end else if (accept) begin
			phase_q   <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			len_q     <= len_d;
			key_q     <= key_d;
			remain_q  <= remain_d;
			key_idx_q <= key_idx_d;
			fin_q     <= fin_d;
			opcode_q  <= opcode_d;
			masked_q  <= masked_d;
		end
	end

	// Result queue storage: the first result goes at the write pointer, an error
	// that follows it goes one place later.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (res_hit) begin
				queue_q[wr_ptr_q] <= res_main;
				if (err_hit) begin
					queue_q[wr_ptr_q + PTR_W'(1)] <= res_err;
				end
			end else if (err_hit) begin
				queue_q[wr_ptr_q] <= res_err;
			end
		end
	end

	// Result queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(n_push) - CNT_W'(pop);
		end
	end

	assign byte_stall   = (count_q > CNT_ROOM);
	assign result_valid = (count_q != '0);
	assign result_beat  = queue_q[rd_ptr_q];

endmodule
